@@ hdl/quicksort_engine_unit_macros.svh @@
// Assertion helpers for the quicksort engine.
`ifndef QUICKSORT_ENGINE_UNIT_MACROS_SVH
`define QUICKSORT_ENGINE_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define QSE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define QSE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qse_pkg.sv @@
`default_nettype none

package qse_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // Command codes of an input item
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SORT   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Status codes of a result item
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        t_op                        operation;
        logic signed [DATA_W-1:0]   value;
        logic [INDEX_W-1:0]         index;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]   value_res;
        logic [COUNT_W-1:0]         count;
        logic [1:0]                 status;
    } t_out_item;

    // Command sequencer states
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_READ,
        TS_SORT
    } t_top_state;

    // Partition sequencer states
    typedef enum logic [3:0] {
        SS_IDLE,
        SS_POP,
        SS_LOAD,
        SS_PIVOT,
        SS_CMP,
        SS_SWP1,
        SS_SWP2,
        SS_FSW1,
        SS_FSW2,
        SS_PUSHL,
        SS_PUSHR
    } t_sort_state;

endpackage

`default_nettype wire

@@ hdl/quicksort_engine_unit.sv @@
// Append and clear: one item per cycle while the result register is free or draining; result
// registered in the cycle after acceptance. Read: no new item until the result is loaded,
// set by the registered read of the element memory. Sort: data dependent, set by the single
// read and write port of the element memory; no item enters.
// Reset (synchronous, active low) empties the set and the range stack; memories hold
// undefined contents until written.
`default_nettype none

`include "quicksort_engine_unit_macros.svh"

module quicksort_engine_unit #(
    parameter int DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire qse_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output qse_pkg::t_out_item      o_out_item
);

    import qse_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W + 1) ? CW : INDEX_W + 1;

    t_top_state        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;
    logic              r_rd_err, n_rd_err;

    logic              w_accept;
    logic              w_full;
    logic              w_idx_bad;
    logic              w_load;
    logic              w_sort_start;
    logic              w_sort_done;

    logic              w_top_we;
    logic              w_sort_we;
    logic [AW-1:0]     w_sort_waddr;
    logic [DATA_W-1:0] w_sort_wdata;
    logic [AW-1:0]     w_sort_raddr;

    logic              m_we;
    logic [AW-1:0]     m_waddr;
    logic [DATA_W-1:0] m_wdata;
    logic [AW-1:0]     m_raddr;
    logic [DATA_W-1:0] m_rdata;

    // Take an item only when idle and the result register is free or draining
    assign o_in_stall = (r_state != TS_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = r_count >= CW'(DEPTH);
    assign w_idx_bad  = (CMPW'(i_in_item.index) >= CMPW'(r_count)) ||
                        (CMPW'(i_in_item.index) >= CMPW'(DEPTH));

    // Element store, shared by the command path and the sorter
    assign m_we    = (r_state == TS_SORT) ? w_sort_we    : w_top_we;
    assign m_waddr = (r_state == TS_SORT) ? w_sort_waddr : AW'(r_count);
    assign m_wdata = (r_state == TS_SORT) ? w_sort_wdata : i_in_item.value;
    assign m_raddr = (r_state == TS_SORT) ? w_sort_raddr : AW'(i_in_item.index);

    qse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_elem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    qse_sorter #(
        .DEPTH (DEPTH)
    ) u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sort_start),
        .i_last  (AW'(r_count - CW'(1))),
        .o_done  (w_sort_done),
        .o_we    (w_sort_we),
        .o_waddr (w_sort_waddr),
        .o_wdata (w_sort_wdata),
        .o_raddr (w_sort_raddr),
        .i_rdata (m_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TS_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.operation)
                        OP_SORT: begin
                            if (r_count >= CW'(2)) n_state = TS_SORT;
                        end
                        OP_READ: n_state = TS_READ;
                        default: n_state = TS_IDLE;
                    endcase
                end
            end
            TS_READ: n_state = TS_IDLE;
            TS_SORT: begin
                if (w_sort_done) n_state = TS_IDLE;
            end
            default: n_state = TS_IDLE;
        endcase
    end

    // Command decode and result loading
    always_comb begin
        n_count      = r_count;
        n_rd_err     = r_rd_err;
        w_top_we     = 1'b0;
        w_sort_start = 1'b0;
        w_load       = 1'b0;
        n_out_item   = r_out_item;
        case (r_state)
            TS_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.operation)
                        OP_APPEND: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                n_out_item = '{value_res: '0, count: COUNT_W'(r_count),
                                               status: STAT_FULL};
                            end else begin
                                w_top_we   = 1'b1;
                                n_count    = r_count + CW'(1);
                                n_out_item = '{value_res: '0,
                                               count: COUNT_W'(r_count + CW'(1)),
                                               status: STAT_OK};
                            end
                        end
                        OP_SORT: begin
                            if (r_count >= CW'(2)) begin
                                w_sort_start = 1'b1;
                            end else begin
                                w_load     = 1'b1;
                                n_out_item = '{value_res: '0, count: COUNT_W'(r_count),
                                               status: STAT_OK};
                            end
                        end
                        OP_READ: begin
                            n_rd_err = w_idx_bad;
                        end
                        OP_CLEAR: begin
                            n_count    = '0;
                            w_load     = 1'b1;
                            n_out_item = '{value_res: '0, count: '0, status: STAT_OK};
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            TS_READ: begin
                w_load     = 1'b1;
                n_out_item = '{value_res: r_rd_err ? '0 : m_rdata,
                               count: COUNT_W'(r_count),
                               status: r_rd_err ? STAT_RANGE : STAT_OK};
            end
            TS_SORT: begin
                if (w_sort_done) begin
                    w_load     = 1'b1;
                    n_out_item = '{value_res: '0, count: COUNT_W'(r_count),
                                   status: STAT_OK};
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Fill the result register on load, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_err    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_err    <= n_rd_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Invariants of the command path and the sorter
    `QSE_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `QSE_ASSERT_SAME(a_done_in_sort, i_clk, i_rst_n, w_sort_done, r_state == TS_SORT, "stray sort done")
    `QSE_ASSERT_NEXT(a_append_count, i_clk, i_rst_n, w_accept && (i_in_item.operation == OP_APPEND) && !w_full, r_count == $past(r_count) + CW'(1), "append lost")
    `QSE_ASSERT_NEXT(a_sort_count, i_clk, i_rst_n, r_state == TS_SORT, r_count == $past(r_count), "count moved in sort")

endmodule

`default_nettype wire

@@ hdl/qse_ram.sv @@
`default_nettype none

module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read with write data forwarded on a same-address hit
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/qse_sorter.sv @@
`default_nettype none

module qse_sorter #(
    parameter int DEPTH = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [$clog2(DEPTH)-1:0]     i_last,
    output logic                              o_done,
    output logic                              o_we,
    output logic [$clog2(DEPTH)-1:0]          o_waddr,
    output logic [qse_pkg::DATA_W-1:0]        o_wdata,
    output logic [$clog2(DEPTH)-1:0]          o_raddr,
    input  wire logic [qse_pkg::DATA_W-1:0]   i_rdata
);

    import qse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 2 * AW;

    t_sort_state       r_state, n_state;
    logic [CW-1:0]     r_sp, n_sp;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_p, n_p;
    logic [AW-1:0]     r_j, n_j;
    logic [DATA_W-1:0] r_pivot, n_pivot;
    logic [DATA_W-1:0] r_vj, n_vj;
    logic [DATA_W-1:0] r_vp, n_vp;

    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [SW-1:0]     s_wdata;
    logic [AW-1:0]     s_raddr;
    logic [SW-1:0]     s_rdata;

    logic              w_le;
    logic              w_last;
    logic              w_push_l;
    logic              w_push_r;

    // Range stack: one {lo, hi} pair per entry
    qse_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Compare the element under scan with the pivot, detect the last scan step, and decide which parts to push
    assign w_le     = $signed(i_rdata) <= $signed(r_pivot);
    assign w_last   = (r_j + AW'(1)) == r_hi;
    assign w_push_l = {1'b0, r_p} > ({1'b0, r_lo} + (AW + 1)'(1));
    assign w_push_r = ({1'b0, r_p} + (AW + 1)'(1)) < {1'b0, r_hi};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SS_IDLE:  if (i_start) n_state = SS_POP;
            SS_POP:   n_state = (r_sp == '0) ? SS_IDLE : SS_LOAD;
            SS_LOAD:  n_state = SS_PIVOT;
            SS_PIVOT: n_state = SS_CMP;
            SS_CMP: begin
                if (w_le) begin
                    n_state = SS_SWP1;
                end else if (w_last) begin
                    n_state = SS_FSW1;
                end
            end
            SS_SWP1:  n_state = SS_SWP2;
            SS_SWP2:  n_state = w_last ? SS_FSW1 : SS_CMP;
            SS_FSW1:  n_state = SS_FSW2;
            SS_FSW2:  n_state = SS_PUSHL;
            SS_PUSHL: n_state = SS_PUSHR;
            SS_PUSHR: n_state = SS_POP;
            default:  n_state = SS_IDLE;
        endcase
    end

    // Memory accesses and datapath updates per state
    always_comb begin
        n_sp    = r_sp;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_p     = r_p;
        n_j     = r_j;
        n_pivot = r_pivot;
        n_vj    = r_vj;
        n_vp    = r_vp;
        o_done  = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_p;
        o_wdata = r_vj;
        o_raddr = r_j;
        s_we    = 1'b0;
        s_waddr = AW'(r_sp);
        s_wdata = {r_lo, r_hi};
        s_raddr = AW'(r_sp - CW'(1));
        case (r_state)
            SS_IDLE: begin
                // seed the stack with the whole set
                if (i_start) begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = {AW'(0), i_last};
                    n_sp    = CW'(1);
                end
            end
            SS_POP: begin
                if (r_sp == '0) begin
                    o_done = 1'b1;
                end else begin
                    n_sp = r_sp - CW'(1);
                end
            end
            SS_LOAD: begin
                n_lo    = s_rdata[SW-1:AW];
                n_hi    = s_rdata[AW-1:0];
                o_raddr = s_rdata[AW-1:0];
            end
            SS_PIVOT: begin
                n_pivot = i_rdata;
                n_p     = r_lo;
                n_j     = r_lo;
                o_raddr = r_lo;
            end
            SS_CMP: begin
                if (w_le) begin
                    n_vj    = i_rdata;
                    o_raddr = r_p;
                end else if (w_last) begin
                    o_raddr = r_p;
                end else begin
                    o_raddr = r_j + AW'(1);
                    n_j     = r_j + AW'(1);
                end
            end
            SS_SWP1: begin
                o_we    = 1'b1;
                o_waddr = r_p;
                o_wdata = r_vj;
                n_vp    = i_rdata;
            end
            SS_SWP2: begin
                o_we    = 1'b1;
                o_waddr = r_j;
                o_wdata = r_vp;
                n_p     = r_p + AW'(1);
                if (w_last) begin
                    o_raddr = r_p + AW'(1);
                end else begin
                    o_raddr = r_j + AW'(1);
                    n_j     = r_j + AW'(1);
                end
            end
            SS_FSW1: begin
                o_we    = 1'b1;
                o_waddr = r_p;
                o_wdata = r_pivot;
                n_vp    = i_rdata;
            end
            SS_FSW2: begin
                o_we    = 1'b1;
                o_waddr = r_hi;
                o_wdata = r_vp;
            end
            SS_PUSHL: begin
                // push the left part only when it holds two or more elements
                if (w_push_l) begin
                    s_we    = 1'b1;
                    s_wdata = {r_lo, r_p - AW'(1)};
                    n_sp    = r_sp + CW'(1);
                end
            end
            SS_PUSHR: begin
                if (w_push_r) begin
                    s_we    = 1'b1;
                    s_wdata = {r_p + AW'(1), r_hi};
                    n_sp    = r_sp + CW'(1);
                end
            end
            default: begin
                n_sp = r_sp;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
    end

    // Hold scan registers
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_p     <= n_p;
        r_j     <= n_j;
        r_pivot <= n_pivot;
        r_vj    <= n_vj;
        r_vp    <= n_vp;
    end

endmodule

`default_nettype wire

@@ bench/quicksort_engine_unit_tb.sv @@
module quicksort_engine_unit_tb;

    import qse_pkg::*;

    localparam int STORE_DEPTH    = 1024;
    localparam int CLK_PERIOD     = 20;
    localparam int RANDOM_ITEMS   = 60;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TIMEOUT_CYCLES = 1_500_000;

    // Mirror of the element store; predicts one response per accepted command
    class sorted_store_tracker;
        logic signed [DATA_W-1:0] held [STORE_DEPTH];
        int unsigned              held_count;
        t_out_item                awaited [$];
        int                       mismatches;

        function void note_command(t_in_item cmd);
            t_out_item                rsp;
            int                       lo_stack [$];
            int                       hi_stack [$];
            int                       lo;
            int                       hi;
            int                       part;
            logic signed [DATA_W-1:0] tmp;
            rsp        = '0;
            rsp.status = STAT_OK;
            case (cmd.operation)
                OP_APPEND: begin
                    if (held_count >= STORE_DEPTH) begin
                        rsp.status = STAT_FULL;
                    end else begin
                        held[held_count] = cmd.value;
                        held_count++;
                    end
                end
                OP_SORT: begin
                    // Iterative Lomuto quicksort, right part taken first
                    if (held_count >= 2) begin
                        lo_stack.push_back(0);
                        hi_stack.push_back(held_count - 1);
                    end
                    while (lo_stack.size() != 0) begin
                        lo = lo_stack.pop_back();
                        hi = hi_stack.pop_back();
                        if (lo >= hi)
                            continue;
                        part = lo;
                        for (int j = lo; j < hi; j++) begin
                            if (held[j] <= held[hi]) begin
                                tmp        = held[part];
                                held[part] = held[j];
                                held[j]    = tmp;
                                part++;
                            end
                        end
                        tmp        = held[part];
                        held[part] = held[hi];
                        held[hi]   = tmp;
                        if (part > lo) begin
                            lo_stack.push_back(lo);
                            hi_stack.push_back(part - 1);
                        end
                        if (part < hi) begin
                            lo_stack.push_back(part + 1);
                            hi_stack.push_back(hi);
                        end
                    end
                end
                OP_READ: begin
                    if (cmd.index >= held_count)
                        rsp.status = STAT_RANGE;
                    else
                        rsp.value_res = held[cmd.index];
                end
                default: begin
                    held_count = 0;
                end
            endcase
            rsp.count = COUNT_W'(held_count);
            awaited.push_back(rsp);
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: value_res=%0d count=%0d status=%0d",
                             got.value_res, got.count, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.value_res !== want.value_res || got.count !== want.count ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response mismatch: expected value_res=%0d count=%0d ",
                              "status=%0d, got value_res=%0d count=%0d status=%0d"},
                             want.value_res, want.count, want.status,
                             got.value_res, got.count, got.status);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    t_in_item  cmd_item;
    logic      rsp_valid;
    logic      rsp_stall;
    t_out_item rsp_item;
    logic      no_gaps;
    logic      no_stalls;

    sorted_store_tracker tracker = new;

    quicksort_engine_unit #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (cmd_valid),
        .o_in_stall (cmd_stall),
        .i_in_item  (cmd_item),
        .o_out_valid(rsp_valid),
        .i_out_stall(rsp_stall),
        .o_out_item (rsp_item)
    );

    // Free-running clock
    initial clk = 1'b0;
    always begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    function automatic t_in_item pack_command(t_op op, logic [DATA_W-1:0] val,
                                              logic [INDEX_W-1:0] idx);
        t_in_item cmd;
        cmd.operation = op;
        cmd.value     = val;
        cmd.index     = idx;
        return cmd;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_command(input t_in_item cmd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= cmd;
        do @(posedge clk); while (!(cmd_valid && !cmd_stall));
        tracker.note_command(cmd);
    endtask

    // Drop valid and wait for every outstanding response
    task automatic hold_until_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Accept responses after a random stall and check each one
    initial begin : response_sink
        int stall_len;
        wait (rst_n === 1'b1);
        forever begin
            stall_len = no_stalls ? 0 : $urandom_range(0, 7);
            if (stall_len > 0) begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge clk);
                @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            tracker.check_response(rsp_item);
        end
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int                 random_sent;
        int                 fill;
        int                 spread;
        logic [DATA_W-1:0]  val;
        t_op                op;

        cmd_valid = 1'b0;
        cmd_item  = '0;
        rsp_stall = 1'b0;
        rst_n     = 1'b0;
        no_gaps   = 1'b0;
        no_stalls = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Empty set: read beyond count, sort of nothing
        send_command(pack_command(OP_READ,   32'h0,         10'd0));
        send_command(pack_command(OP_SORT,   32'hFFFF_FFFF, 10'h3FF));
        // Single element sort
        send_command(pack_command(OP_APPEND, 32'h7FFF_FFFF, 10'h3FF));
        send_command(pack_command(OP_SORT,   32'h0,         10'd0));
        send_command(pack_command(OP_READ,   32'hFFFF_FFFF, 10'd0));
        // Extremes, zero, minus one and a duplicate
        send_command(pack_command(OP_APPEND, 32'h8000_0000, 10'd0));
        send_command(pack_command(OP_APPEND, 32'h0000_0000, 10'h2AA));
        send_command(pack_command(OP_APPEND, 32'hFFFF_FFFF, 10'h155));
        send_command(pack_command(OP_APPEND, 32'h7FFF_FFFF, 10'd0));
        send_command(pack_command(OP_APPEND, 32'h0000_0001, 10'd0));
        send_command(pack_command(OP_SORT,   32'h0,         10'd0));
        for (int i = 0; i < 6; i++)
            send_command(pack_command(OP_READ, 32'h5555_5555, INDEX_W'(i)));
        // Read beyond count, at the boundary and at the top index
        send_command(pack_command(OP_READ,   32'h0,         10'd6));
        send_command(pack_command(OP_READ,   32'h0,         10'h3FF));
        // Repeated sort leaves the set unchanged
        send_command(pack_command(OP_SORT,   32'h0,         10'd0));
        send_command(pack_command(OP_READ,   32'h0,         10'd5));
        send_command(pack_command(OP_CLEAR,  32'hAAAA_AAAA, 10'h3FF));
        send_command(pack_command(OP_READ,   32'h0,         10'd0));
        send_command(pack_command(OP_APPEND, 32'h0000_0005, 10'd0));
        send_command(pack_command(OP_CLEAR,  32'h0,         10'd0));

        // Let the pipe run dry once before the next stage
        hold_until_drained();

        // Fill to capacity, overflow, sort the full set and read it back
        for (int i = 0; i < STORE_DEPTH; i++)
            send_command(pack_command(OP_APPEND, $urandom, INDEX_W'($urandom)));
        repeat (3)
            send_command(pack_command(OP_APPEND, $urandom, INDEX_W'($urandom)));
        send_command(pack_command(OP_READ, $urandom, 10'h3FF));
        send_command(pack_command(OP_SORT, $urandom, INDEX_W'($urandom)));
        send_command(pack_command(OP_READ, $urandom, 10'd0));
        send_command(pack_command(OP_READ, $urandom, 10'h3FF));
        repeat (10)
            send_command(pack_command(OP_READ, $urandom, INDEX_W'($urandom)));
        send_command(pack_command(OP_CLEAR, $urandom, INDEX_W'($urandom)));

        // Random phases: mostly fill, sort and read back, some noise
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
            no_gaps   = ($urandom_range(0, 5) == 0);
            no_stalls = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0) begin
                // Noise: any command with any fields, store kept small
                repeat ($urandom_range(1, 10)) begin
                    op = t_op'($urandom_range(0, 3));
                    if (op == OP_APPEND && tracker.held_count >= 100)
                        op = OP_CLEAR;
                    send_command(pack_command(op, $urandom, INDEX_W'($urandom)));
                    random_sent++;
                end
            end else begin
                if (tracker.held_count > 60 || $urandom_range(0, 1) == 1) begin
                    send_command(pack_command(OP_CLEAR, $urandom, INDEX_W'($urandom)));
                    random_sent++;
                end
                fill   = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                     : $urandom_range(0, 24);
                spread = $urandom_range(0, 2);
                repeat (fill) begin
                    case (spread)
                        0: val = $urandom;
                        1: val = DATA_W'($urandom_range(0, 7)) - 32'd3;
                        default: begin
                            case ($urandom_range(0, 3))
                                0:       val = 32'h8000_0000;
                                1:       val = 32'h7FFF_FFFF;
                                2:       val = 32'hFFFF_FFFF;
                                default: val = $urandom;
                            endcase
                        end
                    endcase
                    send_command(pack_command(OP_APPEND, val, INDEX_W'($urandom)));
                    random_sent++;
                end
                send_command(pack_command(OP_SORT, $urandom, INDEX_W'($urandom)));
                random_sent++;
                if ($urandom_range(0, 3) == 0) begin
                    send_command(pack_command(OP_SORT, $urandom, INDEX_W'($urandom)));
                    random_sent++;
                end
                // Read back, mostly within the count
                repeat ($urandom_range(1, 12)) begin
                    if (tracker.held_count > 0 && $urandom_range(0, 4) != 0)
                        send_command(pack_command(OP_READ, $urandom,
                                     INDEX_W'($urandom_range(0, tracker.held_count - 1))));
                    else
                        send_command(pack_command(OP_READ, $urandom, INDEX_W'($urandom)));
                    random_sent++;
                end
            end
        end

        // Drain and watch for stray responses
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/qse_pkg.sv
hdl/qse_ram.sv
hdl/qse_sorter.sv
hdl/quicksort_engine_unit.sv
bench/quicksort_engine_unit_tb.sv
